[design/qebd_pkg.sv]
// types and constants for the quadrature encoder and button decoder
// no dependencies
`default_nettype none

package qebd_pkg;

  localparam int HIST_DEPTH = 5;
  localparam int CNT_W      = 16;
  localparam int IDX_W      = 3;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CNT_W-1:0] LONG_LIMIT_RST = 16'd2000;
  localparam logic [CNT_W-1:0] MIN_PRESS_RST  = 16'd10;
  localparam logic [CNT_W-1:0] GAP_LIMIT_RST  = 16'd300;

  typedef logic [1:0] pair_t;

  // oldest first
  localparam pair_t CW_SEQ  [HIST_DEPTH] = '{2'b11, 2'b10, 2'b00, 2'b01, 2'b11};
  localparam pair_t CCW_SEQ [HIST_DEPTH] = '{2'b11, 2'b01, 2'b00, 2'b10, 2'b11};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG_LIMIT = 2'd0,
    REG_MIN_PRESS  = 2'd1,
    REG_GAP_LIMIT  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_CW     = 3'd1,
    EV_CCW    = 3'd2,
    EV_PRESS  = 3'd3,
    EV_DOUBLE = 3'd4,
    EV_LONG   = 3'd5
  } event_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_ROT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic rot;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic in_flag;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[design/qebd_in_if.sv]
// sample request channel
// depends on nothing
`default_nettype none

interface qebd_in_if;
  logic valid;
  logic ready;
  logic sample_flag;
  logic pin_a;
  logic pin_b;
  logic pin_button;

  modport source (output valid, output sample_flag, output pin_a, output pin_b,
                  output pin_button, input ready);
  modport sink (input valid, input sample_flag, input pin_a, input pin_b,
                input pin_button, output ready);
endinterface

`default_nettype wire

[design/qebd_out_if.sv]
// event result channel
// depends on nothing
`default_nettype none

interface qebd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;

  modport source (output valid, output event_code, input ready);
  modport sink (input valid, input event_code, output ready);
endinterface

`default_nettype wire

[design/quadrature_encoder_button_decoder.sv]
// Rotary encoder and push button event decoder. Each request carries the A, B
// and button pin levels and a sample flag and yields exactly one event code.
// A request with the flag set runs from acceptance to result in these steps:
// the accepting edge captures the sample, then one walk step per button
// history entry walked (one to five, through a single shared counter step),
// then the rotation pattern match, then the load of the output register,
// which waits while the output still holds an untaken result. A cleared flag
// goes straight to the output register load and gives event none. A new
// request is taken the cycle after the previous one has reached the output
// register, even while that result still waits to be taken.
// top level; depends on qebd_pkg, qebd_in_if, qebd_out_if, qebd_ctrl, qebd_dp
`default_nettype none

module quadrature_encoder_button_decoder
  import qebd_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  qebd_in_if.sink              in_ch,
  qebd_out_if.source           out_ch,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CNT_W-1:0]      cfg_data
);

  cmd_t cmd;
  sts_t sts;

  qebd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qebd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_sample_flag (in_ch.sample_flag),
    .in_pin_a       (in_ch.pin_a),
    .in_pin_b       (in_ch.pin_b),
    .in_pin_button  (in_ch.pin_button),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_event_code (out_ch.event_code),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

`default_nettype wire

[design/qebd_ctrl.sv]
// controller state machine for the decoder
// depends on qebd_pkg
`default_nettype none

module qebd_ctrl
  import qebd_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.in_flag ? ST_WALK : ST_FINISH;
        end
      end
      ST_WALK: begin
        if (sts.walk_done) begin
          state_nxt = ST_ROT;
        end
      end
      ST_ROT: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_WALK: begin
        cmd.step = 1'b1;
      end
      ST_ROT: begin
        cmd.rot = 1'b1;
      end
      ST_FINISH: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/qebd_dp.sv]
// datapath: histories, press and gap counters, pattern match, result register
// depends on qebd_pkg
`default_nettype none

module qebd_dp
  import qebd_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CNT_W-1:0]      cfg_data,
  input  wire                  in_sample_flag,
  input  wire                  in_pin_a,
  input  wire                  in_pin_b,
  input  wire                  in_pin_button,
  input  wire                  out_ready,
  output logic                 out_valid,
  output logic [2:0]           out_event_code,
  input  cmd_t                 cmd,
  output sts_t                 sts
);

  logic [CNT_W-1:0] long_limit_r, min_press_r, gap_limit_r;
  pair_t            rot_hist_r [HIST_DEPTH];
  logic             btn_hist_r [HIST_DEPTH];
  logic [CNT_W-1:0] press_r, press_nxt;
  logic [CNT_W-1:0] gap_r, gap_nxt;
  logic             long_hold_r, long_hold_nxt;
  logic             await_r, await_nxt;
  logic [IDX_W-1:0] idx_r;
  pair_t            pair_r;
  event_t           ev_r, ev_nxt;
  logic             out_valid_r;
  event_t           out_code_r;
  logic             walk_stop;
  logic [CNT_W-1:0] gap_inc;
  logic             rot_change;
  logic             cw_hit, ccw_hit;
  pair_t            rot_new [HIST_DEPTH];

  // one walk step over the button history, oldest first
  always_comb begin
    press_nxt     = press_r;
    gap_nxt       = gap_r;
    long_hold_nxt = long_hold_r;
    await_nxt     = await_r;
    ev_nxt        = EV_NONE;
    walk_stop     = 1'b0;
    gap_inc       = (gap_r == CNT_MAX) ? gap_r : gap_r + 1'b1;
    if (press_r > long_limit_r && !long_hold_r) begin
      press_nxt     = '0;
      long_hold_nxt = 1'b1;
      ev_nxt        = EV_LONG;
      walk_stop     = 1'b1;
    end else if (await_r && gap_inc > gap_limit_r) begin
      await_nxt = 1'b0;
      gap_nxt   = '0;
      ev_nxt    = EV_PRESS;
      walk_stop = 1'b1;
    end else begin
      if (await_r) begin
        gap_nxt = gap_inc;
      end
      if (btn_hist_r[idx_r]) begin
        long_hold_nxt = 1'b0;
        press_nxt     = '0;
        walk_stop     = 1'b1;
        if (press_r >= min_press_r) begin
          if (await_r) begin
            await_nxt = 1'b0;
            ev_nxt    = EV_DOUBLE;
          end else begin
            await_nxt = 1'b1;
            gap_nxt   = '0;
          end
        end
      end else begin
        if (!long_hold_r && press_r != CNT_MAX) begin
          press_nxt = press_r + 1'b1;
        end
        walk_stop = (idx_r == IDX_W'(HIST_DEPTH - 1));
      end
    end
  end

  // rotation history after a changed pair shifts in
  always_comb begin
    rot_change = (rot_hist_r[HIST_DEPTH-1] != pair_r);
    for (int k = 0; k < HIST_DEPTH - 1; k++) begin
      rot_new[k] = rot_hist_r[k+1];
    end
    rot_new[HIST_DEPTH-1] = pair_r;
    cw_hit  = 1'b1;
    ccw_hit = 1'b1;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      if (rot_new[k] != CW_SEQ[k]) begin
        cw_hit = 1'b0;
      end
      if (rot_new[k] != CCW_SEQ[k]) begin
        ccw_hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_limit_r <= LONG_LIMIT_RST;
      min_press_r  <= MIN_PRESS_RST;
      gap_limit_r  <= GAP_LIMIT_RST;
      press_r      <= '0;
      gap_r        <= '0;
      long_hold_r  <= 1'b0;
      await_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < HIST_DEPTH; k++) begin
        rot_hist_r[k] <= '0;
        btn_hist_r[k] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LONG_LIMIT: long_limit_r <= cfg_data;
          REG_MIN_PRESS:  min_press_r  <= cfg_data;
          REG_GAP_LIMIT:  gap_limit_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.load && in_sample_flag) begin
        for (int k = 0; k < HIST_DEPTH - 1; k++) begin
          btn_hist_r[k] <= btn_hist_r[k+1];
        end
        btn_hist_r[HIST_DEPTH-1] <= in_pin_button;
      end
      if (cmd.step) begin
        press_r     <= press_nxt;
        gap_r       <= gap_nxt;
        long_hold_r <= long_hold_nxt;
        await_r     <= await_nxt;
      end
      if (cmd.rot && ev_r == EV_NONE && rot_change) begin
        for (int k = 0; k < HIST_DEPTH; k++) begin
          rot_hist_r[k] <= rot_new[k];
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pair_r <= {in_pin_a, in_pin_b};
      idx_r  <= '0;
      ev_r   <= EV_NONE;
    end
    if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
      ev_r  <= ev_nxt;
    end
    if (cmd.rot && ev_r == EV_NONE && rot_change) begin
      ev_r <= cw_hit ? EV_CW : (ccw_hit ? EV_CCW : EV_NONE);
    end
    if (cmd.emit) begin
      out_code_r <= ev_r;
    end
  end

  assign sts.in_flag   = in_sample_flag;
  assign sts.walk_done = walk_stop;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_event_code = out_code_r;

endmodule

`default_nettype wire
